>>> src/qrs_pkg.sv
// qrs_pkg: shared types and constants of the quadratic root solver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qrs_pkg;

    // coefficient and root width, signed Q16.16
    localparam int CW    = 32;
    // discriminant width, signed Q32.32
    localparam int DW    = 64;
    // exact discriminant magnitude width
    localparam int MAGW  = 67;
    // square root radicand width, padded to an even count
    localparam int RADW  = 68;
    // square root result bits
    localparam int ROOTW = 34;
    // quotient bits formed by the divider
    localparam int QBITS = 34;
    // divider numerator and denominator widths, signed
    localparam int NUMW  = 36;
    localparam int DENW  = 34;

    typedef enum logic [2:0] {
        KIND_ALL     = 3'd0,
        KIND_NONE    = 3'd1,
        KIND_LINEAR  = 3'd2,
        KIND_COMPLEX = 3'd3,
        KIND_DOUBLE  = 3'd4,
        KIND_TWO     = 3'd5
    } t_kind;

    // sideband carried through the square root pipeline
    typedef struct packed {
        t_kind                 kind;
        logic [DW-1:0]         disc;
        logic                  disc_ovf;
        logic signed [CW-1:0]  coef_a;
        logic signed [CW-1:0]  coef_b;
        logic signed [CW-1:0]  coef_c;
    } t_front;

    // sideband carried through the divider pipeline
    typedef struct packed {
        t_kind         kind;
        logic [DW-1:0] disc;
        logic          disc_ovf;
    } t_tail;

endpackage

>>> src/qrs_if.sv
// qrs_in_if and qrs_out_if: valid/ready channels of the solver
// depends on nothing; payload widths follow the coefficient and result formats
`timescale 1ns / 1ps

interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_square;
    logic signed [31:0] coef_linear;
    logic signed [31:0] coef_constant;

    modport source (output valid, output coef_square, output coef_linear,
                    output coef_constant, input ready);
    modport sink   (input valid, input coef_square, input coef_linear,
                    input coef_constant, output ready);
endinterface

interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         solution_kind;
    logic signed [31:0] root_first;
    logic signed [31:0] root_second;
    logic signed [31:0] imag_part;
    logic signed [63:0] discriminant;
    logic               overflow;

    modport source (output valid, output solution_kind, output root_first,
                    output root_second, output imag_part, output discriminant,
                    output overflow, input ready);
    modport sink   (input valid, input solution_kind, input root_first,
                    input root_second, input imag_part, input discriminant,
                    input overflow, output ready);
endinterface

>>> src/qrs_front.sv
// qrs_front: input register, coefficient products and exact discriminant
// depends on qrs_pkg; three register stages, advances on i_en
`timescale 1ns / 1ps

module qrs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [qrs_pkg::CW-1:0]  i_a,
    input  logic signed [qrs_pkg::CW-1:0]  i_b,
    input  logic signed [qrs_pkg::CW-1:0]  i_c,
    output logic                           o_valid,
    output qrs_pkg::t_front                o_data,
    output logic [qrs_pkg::RADW-1:0]       o_rad
);
    import qrs_pkg::*;

    // stage 1: registered coefficients
    logic                 r_v1;
    logic signed [CW-1:0] r_a1, r_b1, r_c1;

    // stage 2: products
    logic                 r_v2;
    logic [2*CW-1:0]      r_bb, r_acm;
    logic                 r_acneg;
    logic signed [CW-1:0] r_a2, r_b2, r_c2;

    // stage 3: classified discriminant
    logic                 r_v3;
    t_front               r_data;
    logic [RADW-1:0]      r_rad;

    logic [CW-1:0]        w_am, w_bm, w_cm;
    logic [MAGW-2:0]      w_q4;
    logic [MAGW-1:0]      w_bbx, w_q4x, w_mag;
    logic                 w_neg;
    t_front               n_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // magnitudes of the coefficients
    always_comb begin
        w_am = r_a1[CW-1] ? (CW'(0) - r_a1) : r_a1;
        w_bm = r_b1[CW-1] ? (CW'(0) - r_b1) : r_b1;
        w_cm = r_c1[CW-1] ? (CW'(0) - r_c1) : r_c1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1    <= i_a;
            r_b1    <= i_b;
            r_c1    <= i_c;
            r_bb    <= w_bm * w_bm;
            r_acm   <= w_am * w_cm;
            r_acneg <= (r_a1[CW-1] ^ r_c1[CW-1]) && (r_a1 != '0) && (r_c1 != '0);
            r_a2    <= r_a1;
            r_b2    <= r_b1;
            r_c2    <= r_c1;
            r_data  <= n_data;
            r_rad   <= {1'b0, w_mag};
        end
    end

    // exact magnitude and sign of b*b - 4ac, then saturation and class
    always_comb begin
        w_q4  = {r_acm, 2'b00};
        w_bbx = {3'b000, r_bb};
        w_q4x = {1'b0, w_q4};
        w_neg = 1'b0;
        if (r_acneg) begin
            w_mag = w_bbx + w_q4x;
        end else if (w_bbx >= w_q4x) begin
            w_mag = w_bbx - w_q4x;
        end else begin
            w_mag = w_q4x - w_bbx;
            w_neg = 1'b1;
        end

        n_data.coef_a   = r_a2;
        n_data.coef_b   = r_b2;
        n_data.coef_c   = r_c2;
        n_data.disc     = '0;
        n_data.disc_ovf = 1'b0;
        if (r_a2 == '0) begin
            if (r_b2 == '0) begin
                n_data.kind = (r_c2 == '0) ? KIND_ALL : KIND_NONE;
            end else begin
                n_data.kind = KIND_LINEAR;
            end
        end else begin
            if (!w_neg) begin
                if (w_mag[MAGW-1:DW-1] != '0) begin
                    n_data.disc     = {1'b0, {(DW-1){1'b1}}};
                    n_data.disc_ovf = 1'b1;
                end else begin
                    n_data.disc = w_mag[DW-1:0];
                end
            end else begin
                if (w_mag > {{(MAGW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}}) begin
                    n_data.disc     = {1'b1, {(DW-1){1'b0}}};
                    n_data.disc_ovf = 1'b1;
                end else begin
                    n_data.disc = DW'(0) - w_mag[DW-1:0];
                end
            end
            if (w_neg) begin
                n_data.kind = KIND_COMPLEX;
            end else if (w_mag == '0) begin
                n_data.kind = KIND_DOUBLE;
            end else begin
                n_data.kind = KIND_TWO;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_data;
    assign o_rad   = r_rad;

endmodule

>>> src/qrs_sqrt.sv
// qrs_sqrt: pipelined integer square root, one result bit per stage
// depends on qrs_pkg; the front sideband travels alongside each stage
`timescale 1ns / 1ps

module qrs_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [qrs_pkg::RADW-1:0]  i_rad,
    input  qrs_pkg::t_front           i_data,
    output logic                      o_valid,
    output logic [qrs_pkg::ROOTW-1:0] o_root,
    output qrs_pkg::t_front           o_data
);
    import qrs_pkg::*;

    localparam int REMW = ROOTW + 2;

    logic             r_v    [ROOTW];
    logic [REMW-1:0]  r_rem  [ROOTW];
    logic [ROOTW-1:0] r_root [ROOTW];
    logic [RADW-1:0]  r_rad  [ROOTW];
    t_front           r_sb   [ROOTW];

    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        logic             w_v_in;
        logic [REMW-1:0]  w_rem_in;
        logic [ROOTW-1:0] w_root_in;
        logic [RADW-1:0]  w_rad_in;
        t_front           w_sb_in;
        logic [REMW:0]    w_tmp, w_trial, w_diff;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
            assign w_sb_in   = i_data;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_sb_in   = r_sb[k-1];
        end

        // trial subtract of 4*root+1 from the remainder with two new bits
        always_comb begin
            w_tmp   = {w_rem_in[REMW-2:0], w_rad_in[RADW-1:RADW-2]};
            w_trial = {1'b0, w_root_in, 2'b01};
            w_diff  = w_tmp - w_trial;
            w_ge    = (w_tmp >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[REMW-1:0] : w_tmp[REMW-1:0];
                r_root[k] <= {w_root_in[ROOTW-2:0], w_ge};
                r_rad[k]  <= {w_rad_in[RADW-3:0], 2'b00};
                r_sb[k]   <= w_sb_in;
            end
        end
    end

    assign o_valid = r_v[ROOTW-1];
    assign o_root  = r_root[ROOTW-1];
    assign o_data  = r_sb[ROOTW-1];

endmodule

>>> src/qrs_div.sv
// qrs_div: two-lane pipelined divider, (num*2^16)/den rounded half away
// from zero and saturated to 32 bits; depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [qrs_pkg::NUMW-1:0]   i_num0,
    input  logic signed [qrs_pkg::NUMW-1:0]   i_num1,
    input  logic signed [qrs_pkg::DENW-1:0]   i_den,
    input  qrs_pkg::t_tail                    i_tail,
    output logic                              o_valid,
    output logic signed [qrs_pkg::CW-1:0]     o_q0,
    output logic signed [qrs_pkg::CW-1:0]     o_q1,
    output logic                              o_ovf0,
    output logic                              o_ovf1,
    output qrs_pkg::t_tail                    o_tail
);
    import qrs_pkg::*;

    localparam int NW   = NUMW + 16 + 2;
    localparam int DVW  = DENW + 1;
    localparam int HIW  = NW - QBITS;

    // stage a: scaled and rounded dividend, doubled divisor
    logic             r_va;
    logic [NW-1:0]    r_n_a   [2];
    logic             r_neg_a [2];
    logic [DVW-1:0]   r_d_a;
    t_tail            r_t_a;

    // stage b: range check and initial remainder
    logic             r_vb;
    logic [DVW-1:0]   r_rem_b [2];
    logic [QBITS-1:0] r_low_b [2];
    logic             r_big_b [2];
    logic             r_neg_b [2];
    logic [DVW-1:0]   r_d_b;
    t_tail            r_t_b;

    // long division steps
    logic             r_v    [QBITS];
    logic [DVW-1:0]   r_rem  [QBITS][2];
    logic [QBITS-1:0] r_low  [QBITS][2];
    logic [QBITS-1:0] r_q    [QBITS][2];
    logic             r_big  [QBITS][2];
    logic             r_neg  [QBITS][2];
    logic [DVW-1:0]   r_d    [QBITS];
    t_tail            r_t    [QBITS];

    // final saturation stage
    logic             r_vf;
    logic [CW-1:0]    r_qf   [2];
    logic             r_ovf  [2];
    t_tail            r_tf;

    logic [NUMW-1:0]  w_num  [2];
    logic [NUMW-1:0]  w_nmag [2];
    logic [DENW-1:0]  w_dm;
    logic [CW-1:0]    n_qf   [2];
    logic             n_ovf  [2];

    always_comb begin
        w_num[0] = i_num0;
        w_num[1] = i_num1;
        w_dm     = i_den[DENW-1] ? (DENW'(0) - i_den) : i_den;
        for (int l = 0; l < 2; l++) begin
            w_nmag[l] = w_num[l][NUMW-1] ? (NUMW'(0) - w_num[l]) : w_num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_a <= {w_dm, 1'b0};
            r_t_a <= i_tail;
            r_d_b <= r_d_a;
            r_t_b <= r_t_a;
            for (int l = 0; l < 2; l++) begin
                r_n_a[l]   <= {1'b0, w_nmag[l], 16'b0, 1'b0}
                            + {{(NW-DENW){1'b0}}, w_dm};
                r_neg_a[l] <= w_num[l][NUMW-1] ^ i_den[DENW-1];
                r_big_b[l] <= {{(DVW-HIW){1'b0}}, r_n_a[l][NW-1:QBITS]} >= r_d_a;
                r_rem_b[l] <= {{(DVW-HIW){1'b0}}, r_n_a[l][NW-1:QBITS]};
                r_low_b[l] <= r_n_a[l][QBITS-1:0];
                r_neg_b[l] <= r_neg_a[l];
            end
        end
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic             w_v_in;
        logic [DVW-1:0]   w_rem_in [2];
        logic [QBITS-1:0] w_low_in [2];
        logic [QBITS-1:0] w_q_in   [2];
        logic             w_big_in [2];
        logic             w_neg_in [2];
        logic [DVW-1:0]   w_d_in;
        t_tail            w_t_in;
        logic [DVW:0]     w_tmp    [2];
        logic [DVW:0]     w_diff   [2];
        logic             w_ge     [2];

        if (k == 0) begin : g_first
            assign w_v_in = r_vb;
            assign w_d_in = r_d_b;
            assign w_t_in = r_t_b;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign w_rem_in[l] = r_rem_b[l];
                assign w_low_in[l] = r_low_b[l];
                assign w_q_in[l]   = '0;
                assign w_big_in[l] = r_big_b[l];
                assign w_neg_in[l] = r_neg_b[l];
            end
        end else begin : g_next
            assign w_v_in = r_v[k-1];
            assign w_d_in = r_d[k-1];
            assign w_t_in = r_t[k-1];
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign w_rem_in[l] = r_rem[k-1][l];
                assign w_low_in[l] = r_low[k-1][l];
                assign w_q_in[l]   = r_q[k-1][l];
                assign w_big_in[l] = r_big[k-1][l];
                assign w_neg_in[l] = r_neg[k-1][l];
            end
        end

        // one restoring division step per lane
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_tmp[l]  = {w_rem_in[l], w_low_in[l][QBITS-1]};
                w_diff[l] = w_tmp[l] - {1'b0, w_d_in};
                w_ge[l]   = (w_tmp[l] >= {1'b0, w_d_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k] <= w_d_in;
                r_t[k] <= w_t_in;
                for (int l = 0; l < 2; l++) begin
                    r_rem[k][l] <= w_ge[l] ? w_diff[l][DVW-1:0] : w_tmp[l][DVW-1:0];
                    r_low[k][l] <= {w_low_in[l][QBITS-2:0], 1'b0};
                    r_q[k][l]   <= {w_q_in[l][QBITS-2:0], w_ge[l]};
                    r_big[k][l] <= w_big_in[l];
                    r_neg[k][l] <= w_neg_in[l];
                end
            end
        end
    end

    // sign and saturation of the quotients
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_ovf[l] = 1'b0;
            if (!r_neg[QBITS-1][l]) begin
                if (r_big[QBITS-1][l] || (r_q[QBITS-1][l][QBITS-1:CW-1] != '0)) begin
                    n_qf[l]  = {1'b0, {(CW-1){1'b1}}};
                    n_ovf[l] = 1'b1;
                end else begin
                    n_qf[l] = r_q[QBITS-1][l][CW-1:0];
                end
            end else begin
                if (r_big[QBITS-1][l] ||
                    (r_q[QBITS-1][l] > {{(QBITS-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}})) begin
                    n_qf[l]  = {1'b1, {(CW-1){1'b0}}};
                    n_ovf[l] = 1'b1;
                end else begin
                    n_qf[l] = CW'(0) - r_q[QBITS-1][l][CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_vf <= r_v[QBITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tf <= r_t[QBITS-1];
            for (int l = 0; l < 2; l++) begin
                r_qf[l]  <= n_qf[l];
                r_ovf[l] <= n_ovf[l];
            end
        end
    end

    assign o_valid = r_vf;
    assign o_q0    = r_qf[0];
    assign o_q1    = r_qf[1];
    assign o_ovf0  = r_ovf[0];
    assign o_ovf1  = r_ovf[1];
    assign o_tail  = r_tf;

endmodule

>>> src/quadratic_root_solver_top.sv
// quadratic_root_solver_top: classifies and solves a*x^2+b*x+c=0 in Q16.16
// depends on qrs_pkg, qrs_if, qrs_front, qrs_sqrt and qrs_div
`timescale 1ns / 1ps

// Takes one coefficient set per cycle while i_coef.ready is high and returns one
// result per coefficient set, in order. From input transfer to output valid, a
// set passes the register stages for the products and the exact discriminant,
// the square root (one result bit per stage), the two-lane divider (operand
// scaling, range check, 34 quotient-bit stages, saturation) and the output
// register. All stages advance together; when the output register
// holds a result that has not been taken, the pipeline still moves while its
// last stage is empty, so input transfers go on until the bubbles are used up.
module quadratic_root_solver_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrs_in_if.sink    i_coef,
    qrs_out_if.source o_res
);
    import qrs_pkg::*;

    logic                     w_en, w_load;
    logic                     w_front_v, w_sqrt_v, w_div_v;
    t_front                   w_front_d, w_sqrt_d;
    logic [RADW-1:0]          w_rad;
    logic [ROOTW-1:0]         w_root;
    logic signed [NUMW-1:0]   w_nb, w_sv, w_num0, w_num1;
    logic signed [DENW-1:0]   w_den;
    t_tail                    w_tail, w_div_tail;
    logic signed [CW-1:0]     w_q0, w_q1;
    logic                     w_ovf0, w_ovf1;

    logic                     r_out_v;
    logic [2:0]               r_kind;
    logic signed [CW-1:0]     r_r1, r_r2, r_im;
    logic [DW-1:0]            r_disc;
    logic                     r_ovf;

    logic [2:0]               n_kind;
    logic signed [CW-1:0]     n_r1, n_r2, n_im;
    logic [DW-1:0]            n_disc;
    logic                     n_ovf;

    // pipeline advance and output register load
    assign w_load       = !r_out_v || o_res.ready;
    assign w_en         = w_load || !w_div_v;
    assign i_coef.ready = w_en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_coef.valid),
        .i_a     (i_coef.coef_square),
        .i_b     (i_coef.coef_linear),
        .i_c     (i_coef.coef_constant),
        .o_valid (w_front_v),
        .o_data  (w_front_d),
        .o_rad   (w_rad)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_rad   (w_rad),
        .i_data  (w_front_d),
        .o_valid (w_sqrt_v),
        .o_root  (w_root),
        .o_data  (w_sqrt_d)
    );

    // divider operands per solution kind
    always_comb begin
        w_nb = NUMW'(0) - NUMW'(w_sqrt_d.coef_b);
        w_sv = $signed({{(NUMW-ROOTW){1'b0}}, w_root});
        if (w_sqrt_d.kind == KIND_LINEAR) begin
            w_den = DENW'(w_sqrt_d.coef_b);
        end else begin
            w_den = {w_sqrt_d.coef_a[CW-1], w_sqrt_d.coef_a, 1'b0};
        end
        case (w_sqrt_d.kind)
            KIND_LINEAR: begin
                w_num0 = NUMW'(0) - NUMW'(w_sqrt_d.coef_c);
                w_num1 = '0;
            end
            KIND_TWO: begin
                w_num0 = w_nb - w_sv;
                w_num1 = w_nb + w_sv;
            end
            KIND_COMPLEX: begin
                w_num0 = w_nb;
                w_num1 = w_sv;
            end
            default: begin
                w_num0 = w_nb;
                w_num1 = '0;
            end
        endcase
        w_tail.kind     = w_sqrt_d.kind;
        w_tail.disc     = w_sqrt_d.disc;
        w_tail.disc_ovf = w_sqrt_d.disc_ovf;
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_v),
        .i_num0  (w_num0),
        .i_num1  (w_num1),
        .i_den   (w_den),
        .i_tail  (w_tail),
        .o_valid (w_div_v),
        .o_q0    (w_q0),
        .o_q1    (w_q1),
        .o_ovf0  (w_ovf0),
        .o_ovf1  (w_ovf1),
        .o_tail  (w_div_tail)
    );

    // result assembly and root ordering
    always_comb begin
        n_kind = w_div_tail.kind;
        n_disc = w_div_tail.disc;
        n_r1   = '0;
        n_r2   = '0;
        n_im   = '0;
        n_ovf  = 1'b0;
        case (w_div_tail.kind)
            KIND_LINEAR, KIND_DOUBLE: begin
                n_r1  = w_q0;
                n_r2  = w_q0;
                n_ovf = w_div_tail.disc_ovf | w_ovf0;
            end
            KIND_COMPLEX: begin
                n_r1  = w_q0;
                n_r2  = w_q0;
                n_im  = w_q1;
                n_ovf = w_div_tail.disc_ovf | w_ovf0 | w_ovf1;
            end
            KIND_TWO: begin
                n_r1  = (w_q0 > w_q1) ? w_q1 : w_q0;
                n_r2  = (w_q0 > w_q1) ? w_q0 : w_q1;
                n_ovf = w_div_tail.disc_ovf | w_ovf0 | w_ovf1;
            end
            default: begin
                n_disc = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_r1   <= n_r1;
            r_r2   <= n_r2;
            r_im   <= n_im;
            r_disc <= n_disc;
            r_ovf  <= n_ovf;
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.solution_kind = r_kind;
    assign o_res.root_first    = r_r1;
    assign o_res.root_second   = r_r2;
    assign o_res.imag_part     = r_im;
    assign o_res.discriminant  = r_disc;
    assign o_res.overflow      = r_ovf;

    // two real roots leave lower first
    a_two_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_kind == KIND_TWO) |-> (r_r1 <= r_r2))
        else $error("two real roots out of order");

    // imaginary part only for a complex pair
    a_imag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_kind != KIND_COMPLEX) |-> (r_im == '0))
        else $error("imaginary part set outside complex pair");

    // no discriminant and no roots without a quadratic or linear term
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_kind == KIND_ALL || r_kind == KIND_NONE))
            |-> (r_r1 == '0 && r_r2 == '0 && r_disc == '0 && !r_ovf))
        else $error("degenerate equation with nonzero result");

    // linear root carries no discriminant
    a_linear_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_kind == KIND_LINEAR) |-> (r_disc == '0 && r_r1 == r_r2))
        else $error("linear result with discriminant");

endmodule

>>> sim/qrs_checker.sv
// qrs_checker: watches both channels of the quadratic root solver, predicts each result
// depends on qrs_pkg and the qrs_in_if / qrs_out_if interfaces
`timescale 1ns / 1ps

module qrs_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qrs_in_if     i_coef,
    qrs_out_if    i_res,
    output int    o_fail_count,
    output int    o_pending,
    output logic  o_transfer
);
    import qrs_pkg::*;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] root_lo;
        logic signed [31:0] root_hi;
        logic signed [31:0] imag;
        logic signed [63:0] disc;
        logic               ovf;
    } t_solution;

    t_solution solutions_due[$];
    int        fail_count = 0;

    // (num << 16) / den, rounded half away from zero, saturated to Q16.16
    function automatic logic signed [31:0] fx_quotient(input logic signed [127:0] num,
                                                       input logic signed [127:0] den,
                                                       inout logic ovf);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        nm  = (num < 0 ? -num : num) << 16;
        dm  = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        if (dm == 0) return 32'sd0;
        q = (2 * nm + dm) / (2 * dm);
        if (!neg && q > 128'h7FFFFFFF) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (neg && q > 128'h80000000) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // floor of the square root of a magnitude below 2^67
    function automatic logic [127:0] floor_sqrt(input logic [127:0] m);
        logic [127:0] r;
        logic [127:0] cand;
        r = '0;
        for (int bit_idx = 33; bit_idx >= 0; bit_idx--) begin
            cand = r | (128'd1 << bit_idx);
            if (cand * cand <= m) r = cand;
        end
        return r;
    endfunction

    function automatic t_solution solve_quadratic(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic signed [31:0] c);
        t_solution          sol;
        logic signed [127:0] wa, wb, wc, d, s, den;
        logic signed [31:0] r1, r2;
        sol = '{kind: KIND_ALL, root_lo: 0, root_hi: 0, imag: 0, disc: 0, ovf: 0};
        wa = a;
        wb = b;
        wc = c;
        if (a == 0 && b == 0) begin
            sol.kind = (c == 0) ? KIND_ALL : KIND_NONE;
        end else if (a == 0) begin
            sol.kind    = KIND_LINEAR;
            sol.root_lo = fx_quotient(-wc, wb, sol.ovf);
            sol.root_hi = sol.root_lo;
        end else begin
            d   = wb * wb - 4 * wa * wc;
            den = 2 * wa;
            // discriminant saturates, classification uses the exact value
            if (d > 128'sh7FFFFFFFFFFFFFFF) begin
                sol.disc = 64'sh7FFFFFFFFFFFFFFF;
                sol.ovf  = 1'b1;
            end else if (d < -(128'sh8000000000000000)) begin
                sol.disc = 64'sh8000000000000000;
                sol.ovf  = 1'b1;
            end else begin
                sol.disc = d[63:0];
            end
            if (d < 0) begin
                sol.kind    = KIND_COMPLEX;
                s           = floor_sqrt(-d);
                sol.root_lo = fx_quotient(-wb, den, sol.ovf);
                sol.root_hi = sol.root_lo;
                sol.imag    = fx_quotient(s, den, sol.ovf);
            end else if (d == 0) begin
                sol.kind    = KIND_DOUBLE;
                sol.root_lo = fx_quotient(-wb, den, sol.ovf);
                sol.root_hi = sol.root_lo;
            end else begin
                sol.kind = KIND_TWO;
                s        = floor_sqrt(d);
                r1       = fx_quotient(-wb - s, den, sol.ovf);
                r2       = fx_quotient(-wb + s, den, sol.ovf);
                sol.root_lo = (r1 > r2) ? r2 : r1;
                sol.root_hi = (r1 > r2) ? r1 : r2;
            end
        end
        return sol;
    endfunction

    assign o_fail_count = fail_count;
    assign o_pending    = solutions_due.size();
    assign o_transfer   = (i_coef.valid && i_coef.ready) || (i_res.valid && i_res.ready);

    // predict on every coefficient transfer, compare on every result transfer
    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n) begin
            if (i_coef.valid && i_coef.ready)
                solutions_due.push_back(solve_quadratic(i_coef.coef_square,
                                        i_coef.coef_linear, i_coef.coef_constant));
            if (i_res.valid && i_res.ready) begin
                if (solutions_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: kind %0d", i_res.solution_kind);
                end else begin
                    want = solutions_due.pop_front();
                    if (i_res.solution_kind !== want.kind || i_res.root_first !== want.root_lo
                        || i_res.root_second !== want.root_hi || i_res.imag_part !== want.imag
                        || i_res.discriminant !== want.disc || i_res.overflow !== want.ovf) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch exp kind %0d r1 %h r2 %h im %h d %h ov %b",
                                     want.kind, want.root_lo, want.root_hi, want.imag,
                                     want.disc, want.ovf);
                            $display("         got kind %0d r1 %h r2 %h im %h d %h ov %b",
                                     i_res.solution_kind, i_res.root_first,
                                     i_res.root_second, i_res.imag_part,
                                     i_res.discriminant, i_res.overflow);
                        end
                    end
                end
            end
        end
    end

endmodule

>>> sim/quadratic_root_solver_top_test.sv
// quadratic_root_solver_top_test: drives coefficient sets and gives the verdict
// depends on qrs_pkg, qrs_if, quadratic_root_solver_top and qrs_checker
`timescale 1ns / 1ps

module quadratic_root_solver_top_test;
    import qrs_pkg::*;

    localparam int LATENCY     = 75;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic transfer;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_request = 1'b0;
    int   quiet_cycles = 0;

    qrs_in_if  coef_ch ();
    qrs_out_if res_ch ();

    quadratic_root_solver_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_ch),
        .o_res   (res_ch)
    );

    qrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coef       (coef_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_transfer   (transfer)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        coef_ch.valid         = 1'b0;
        coef_ch.coef_square   = '0;
        coef_ch.coef_linear   = '0;
        coef_ch.coef_constant = '0;
        res_ch.ready          = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        quiet_cycles <= transfer ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_coefs(input logic signed [31:0] a, input logic signed [31:0] b,
                              input logic signed [31:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            coef_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        coef_ch.valid         <= 1'b1;
        coef_ch.coef_square   <= a;
        coef_ch.coef_linear   <= b;
        coef_ch.coef_constant <= c;
        do @(posedge i_clk); while (!coef_ch.ready);
    endtask

    function automatic logic signed [31:0] pick_coef();
        case ($urandom_range(5))
            0: return $signed($urandom);
            1: return $signed($urandom_range(8)) - 4;
            2: return ($signed($urandom_range(200)) - 100) <<< 16;
            3: return $signed($urandom_range(2000000)) - 1000000;
            4: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return '0;
        endcase
    endfunction

    // random coefficient sets, weighted toward solvable and boundary shapes
    task automatic send_random(input int count);
        logic signed [31:0] a, b, c, p, q;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1: send_coefs($signed($urandom), $signed($urandom), $signed($urandom));
                2: begin
                    // exact double root
                    p = $signed($urandom_range(60)) - 30;
                    q = $signed($urandom_range(600)) - 300;
                    if (p == 0) p = 1;
                    send_coefs(p, 2 * p * q, p * q * q);
                end
                3: send_coefs('0, pick_coef(), pick_coef());
                4: send_coefs('0, '0, $urandom_range(1) ? 32'sd0 : pick_coef());
                default: begin
                    a = pick_coef();
                    b = pick_coef();
                    c = pick_coef();
                    send_coefs(a, b, c);
                end
            endcase
        end
    endtask

    task automatic drain();
        coef_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every solution kind, field extremes, saturation
        send_coefs(0, 0, 0);
        send_coefs(0, 0, 32'sh00010000);
        send_coefs(0, 0, 32'sh80000000);
        send_coefs(0, 32'sh00020000, 32'sh00010000);
        send_coefs(0, 1, 32'sh7FFFFFFF);
        send_coefs(0, 1, 32'sh80000000);
        send_coefs(0, -1, 32'sh80000000);
        send_coefs(32'sh00010000, 0, 32'sh00010000);
        send_coefs(32'sh00010000, 32'sh00020000, 32'sh00010000);
        send_coefs(32'sh00010000, 0, -32'sh00040000);
        send_coefs(32'sh00010000, -32'sh00030000, 32'sh00020000);
        send_coefs(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        send_coefs(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        send_coefs(32'sh7FFFFFFF, 0, 32'sh7FFFFFFF);
        send_coefs(32'sh80000000, 0, 32'sh80000000);
        send_coefs(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        send_coefs(1, 32'sh7FFFFFFF, 0);
        send_coefs(-1, 32'sh80000000, 1);
        send_coefs(1, 0, 1);
        send_coefs(1, 3, 1);
        send_coefs(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_coefs(-1, -1, -1);
        drain();

        // no idling, with a long result hold-off while the input keeps offering
        hold_request = 1'b1;
        send_random(360);
        drain();

        send_idle_pct = 60;
        send_random(360);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 60;
        send_random(360);
        drain();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_random(360);
        drain();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
src/qrs_pkg.sv
src/qrs_if.sv
src/qrs_front.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver_top.sv
sim/qrs_checker.sv
sim/quadratic_root_solver_top_test.sv
